@@ hw/rtl/icf_pkg.sv @@
// Shared types, constants and helper functions for the tilt and gyro fusion block.
`timescale 1ns / 1ps
package icf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN     = 3'd4;

  localparam logic [16:0] BLEND_WEIGHT_RST = 17'd64225;
  localparam logic [31:0] GYRO_GAIN_RST    = 32'd32786080;
  localparam logic [16:0] WEIGHT_ONE       = 17'd65536;
  localparam logic [19:0] ROUND_HALF_US    = 20'd500000;
  localparam logic [19:0] US_PER_S         = 20'd1000000;

  // Reciprocal of one million: exact quotient for any 32-bit dividend.
  localparam logic [32:0] US_RECIP       = 33'd4503599628;
  localparam int          US_RECIP_SHIFT = 52;

  // One sample as accepted by the front end.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [19:0] elapsed_us;
    logic               seed;
  } sample_t;

  // One result as delivered.
  typedef struct packed {
    logic signed [31:0] fused_x;
    logic signed [31:0] fused_y;
    logic signed [31:0] fused_z;
    logic signed [23:0] tilt_x;
    logic signed [23:0] tilt_y;
    logic signed [23:0] tilt_z;
  } result_t;

  // Register file contents handed to the back end.
  typedef struct packed {
    logic        [16:0] blend_weight;
    logic signed [15:0] gyro_offset_x;
    logic signed [15:0] gyro_offset_y;
    logic signed [15:0] gyro_offset_z;
    logic        [31:0] gyro_gain;
  } cfg_t;

  // Arctangent in Q24 degrees.
  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = 30'd754974720;
      5'd1:  atan_q24 = 30'd445687602;
      5'd2:  atan_q24 = 30'd235489088;
      5'd3:  atan_q24 = 30'd119537938;
      5'd4:  atan_q24 = 30'd60000934;
      5'd5:  atan_q24 = 30'd30029717;
      5'd6:  atan_q24 = 30'd15018523;
      5'd7:  atan_q24 = 30'd7509720;
      5'd8:  atan_q24 = 30'd3754917;
      5'd9:  atan_q24 = 30'd1877466;
      5'd10: atan_q24 = 30'd938734;
      5'd11: atan_q24 = 30'd469367;
      5'd12: atan_q24 = 30'd234684;
      5'd13: atan_q24 = 30'd117342;
      5'd14: atan_q24 = 30'd58671;
      5'd15: atan_q24 = 30'd29335;
      5'd16: atan_q24 = 30'd14668;
      5'd17: atan_q24 = 30'd7334;
      5'd18: atan_q24 = 30'd3667;
      5'd19: atan_q24 = 30'd1833;
      5'd20: atan_q24 = 30'd917;
      5'd21: atan_q24 = 30'd458;
      5'd22: atan_q24 = 30'd229;
      5'd23: atan_q24 = 30'd115;
      5'd24: atan_q24 = 30'd57;
      5'd25: atan_q24 = 30'd29;
      5'd26: atan_q24 = 30'd14;
      5'd27: atan_q24 = 30'd7;
      5'd28: atan_q24 = 30'd4;
      5'd29: atan_q24 = 30'd2;
      5'd30: atan_q24 = 30'd1;
      default: atan_q24 = 30'd0;
    endcase
  endfunction

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ hw/rtl/icf_if.sv @@
// Valid/ready stream interface carrying one payload.
`timescale 1ns / 1ps
interface icf_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/icf_front.sv @@
// Front end: accepts samples, tags the seeding sample and queues them.
`timescale 1ns / 1ps
module icf_front
  import icf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sample_t            in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output sample_t            q_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  sample_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               seeded;
  logic               push;
  logic               pop;
  sample_t            tagged_sample;

  assign in_ready = (count != QUEUE_DEPTH[PTR_W:0]);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rd_ptr];

  // Mark the first sample after reset as the seed.
  always_comb begin
    tagged_sample      = in_data;
    tagged_sample.seed = !seeded;
  end

  // Store queue entries.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= tagged_sample;
  end

  // Advance pointers and seed flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      seeded <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        seeded <= 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end
  end

endmodule

@@ hw/rtl/icf_back.sv @@
// Back end: square root, shared CORDIC, gyro increment and blend, one axis at a time.
`timescale 1ns / 1ps
module icf_back
  import icf_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_ready,
  input  sample_t q_data,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data,
  output logic    busy
);

  localparam int SHIFT_S = 24 - ANGLE_FRAC_BITS;
  localparam int GSHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int STEP_W  = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SQRT  = 9'b000000010,
    ST_CORD  = 9'b000000100,
    ST_ROUND = 9'b000001000,
    ST_GMUL  = 9'b000010000,
    ST_TMUL  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_BLEND = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state;
  sample_t smp;
  logic [1:0]  axis;
  logic [5:0]  cnt;
  logic [STEP_W-1:0] step;

  // Per-axis operands.
  logic signed [15:0] num_a, p_a, q_a, rate_a, off_a;
  logic signed [31:0] kept_a;

  // Square root state.
  logic [49:0] rad;
  logic [24:0] root;
  logic [26:0] rem;

  // CORDIC state.
  logic signed [33:0] cx, cy;
  logic signed [35:0] cz;
  logic               cord_init;
  logic signed [31:0] tilt;

  // Gyro state.
  logic [16:0] dmag;
  logic        dneg;
  logic [48:0] tval;
  logic [71:0] prod;
  logic [71:0] quo;
  logic [19:0] drem;
  logic [11:0] qdig;
  logic signed [49:0] inc;

  logic signed [31:0] angle [3];
  logic signed [23:0] tilts [3];
  logic signed [31:0] fused [3];
  result_t out_reg;
  logic    out_valid;

  // Choose operands for the current axis.
  always_comb begin
    case (axis)
      2'd0: begin
        num_a = smp.accel_y; p_a = smp.accel_x; q_a = smp.accel_z;
        rate_a = smp.rate_x; off_a = cfg.gyro_offset_x;
      end
      2'd1: begin
        num_a = smp.accel_x; p_a = smp.accel_y; q_a = smp.accel_z;
        rate_a = smp.rate_y; off_a = cfg.gyro_offset_y;
      end
      default: begin
        num_a = smp.accel_z; p_a = smp.accel_y; q_a = smp.accel_x;
        rate_a = smp.rate_z; off_a = cfg.gyro_offset_z;
      end
    endcase
    kept_a = angle[axis];
  end

  // One square root step, one CORDIC step, one divide digit, the tilt rounding and the blend.
  logic [26:0] trial;
  logic [26:0] rem_sh;
  logic signed [33:0] dx, dy;
  logic signed [35:0] zr;
  logic signed [36:0] rnd;
  logic signed [16:0] dval;
  logic [31:0] dnum;
  logic [64:0] qprod;
  logic [16:0] kw;
  logic signed [49:0] ssum;
  logic signed [31:0] skept;
  logic signed [66:0] acc;
  logic signed [50:0] blended;

  always_comb begin
    rem_sh  = {rem[24:0], rad[49:48]};
    trial   = {root, 2'b01};
    dx      = cy >>> step;
    dy      = cx >>> step;
    zr      = cz + (SHIFT_S > 0 ? (36'sd1 <<< (SHIFT_S > 0 ? SHIFT_S - 1 : 0)) : 36'sd0);
    rnd     = -(37'(zr >>> SHIFT_S));
    dval    = 17'(rate_a) - 17'(off_a);
    dnum    = {drem, prod[71:60]};
    qprod   = 65'(dnum) * 65'(US_RECIP);
    kw      = (cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.blend_weight;
    ssum    = 50'(kept_a) + inc;
    skept   = sat32(ssum);
    acc     = 67'($signed({1'b0, kw})) * 67'(skept)
            + 67'($signed({1'b0, WEIGHT_ONE - kw})) * 67'(tilt) + 67'sd32768;
    blended = 51'(acc >>> 16);
  end

  // Sequence the per-axis work.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) angle[i] <= '0;
    end else begin
      // Raise the result on load, drop it once taken.
      if (state == ST_OUT && (!out_valid || res_ready)) out_valid <= 1'b1;
      else if (res_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            smp   <= q_data;
            axis  <= 2'd0;
            state <= ST_SQRT;
            cnt   <= 6'd0;
            rad   <= '0;
          end
        end
        ST_SQRT: begin
          if (cnt == 6'd0) begin
            rad  <= {1'b0, (33'($signed(p_a) * $signed(p_a))
                    + 33'($signed(q_a) * $signed(q_a))), 16'd0};
            root <= '0;
            rem  <= '0;
            cnt  <= 6'd1;
          end else begin
            rad <= {rad[47:0], 2'b00};
            if (rem_sh >= trial) begin
              rem  <= rem_sh - trial;
              root <= {root[23:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              root <= {root[23:0], 1'b0};
            end
            if (cnt == 6'd25) begin
              state     <= ST_CORD;
              step      <= '0;
              cord_init <= 1'b1;
            end
            cnt <= cnt + 6'd1;
          end
        end
        ST_CORD: begin
          if (cord_init) begin
            cx        <= 34'({9'd0, root});
            cy        <= 34'(num_a) <<< 8;
            cz        <= '0;
            cord_init <= 1'b0;
          end else begin
            if (cy >= 0) begin
              cx <= cx + dx; cy <= cy - dy;
              cz <= cz + 36'(atan_q24(5'(step)));
            end else begin
              cx <= cx - dx; cy <= cy + dy;
              cz <= cz - 36'(atan_q24(5'(step)));
            end
            if (step == STEP_W'(CORDIC_STEPS - 1)) state <= ST_ROUND;
            step <= step + 1'b1;
          end
        end
        ST_ROUND: begin
          tilt  <= (num_a == 16'sd0) ? 32'sd0 : rnd[31:0];
          tilts[axis] <= (num_a == 16'sd0) ? 24'sd0 : rnd[23:0];
          dneg  <= dval[16];
          dmag  <= dval[16] ? 17'(-dval) : 17'(dval);
          state <= smp.seed ? ST_BLEND : ST_GMUL;
        end
        ST_GMUL: begin
          tval  <= 49'((66'(dmag) * 66'(cfg.gyro_gain)) >> GSHIFT);
          state <= ST_TMUL;
        end
        ST_TMUL: begin
          prod  <= 72'(tval) * 72'(smp.elapsed_us) + 72'(ROUND_HALF_US);
          quo   <= '0;
          drem  <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Six 12-bit quotient digits, each an estimate step and then a remainder step.
          if (!cnt[0]) begin
            qdig <= qprod[US_RECIP_SHIFT+11:US_RECIP_SHIFT];
          end else begin
            drem <= 20'(dnum - 32'(qdig) * 32'(US_PER_S));
            quo  <= {quo[59:0], qdig};
            prod <= {prod[59:0], 12'd0};
          end
          if (cnt == 6'd11) state <= ST_BLEND;
          cnt <= cnt + 6'd1;
        end
        ST_BLEND: begin
          if (smp.seed) fused[axis] <= 32'(tilt);
          else fused[axis] <= sat32(50'(blended));
          if (smp.seed) angle[axis] <= 32'(tilt);
          else angle[axis] <= sat32(50'(blended));
          if (axis == 2'd2) state <= ST_OUT;
          else begin
            axis  <= axis + 2'd1;
            cnt   <= 6'd0;
            state <= ST_SQRT;
          end
        end
        ST_OUT: begin
          if (!out_valid || res_ready) begin
            out_reg.fused_x <= fused[0];
            out_reg.fused_y <= fused[1];
            out_reg.fused_z <= fused[2];
            out_reg.tilt_x  <= tilts[0];
            out_reg.tilt_y  <= tilts[1];
            out_reg.tilt_z  <= tilts[2];
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Signed increment from the quotient.
  always_comb inc = dneg ? -50'(quo[48:0]) : 50'(quo[48:0]);

  assign q_ready   = (state == ST_IDLE);
  assign res_valid = out_valid;
  assign res_data  = out_reg;
  assign busy      = (state != ST_IDLE) || out_valid;

endmodule

@@ hw/rtl/imu_complementary_filter.sv @@
// Top level: register file, front end, queue and back end of the fusion block.
`timescale 1ns / 1ps
// Tilt and gyro fusion block.
// Samples enter on the in channel (valid/ready). Each gives one result on the
// out channel: three fused angles (Q16.16 degrees, saturated) and three
// accelerometer tilt angles. Registers are written through cfg_we, cfg_index
// and cfg_data; write them only while the block is idle.
// A two-entry queue lets the front take samples while the back is busy.
// Each axis runs a 25-step square root, CORDIC_STEPS CORDIC iterations on
// one shared rotator, two multiply steps and a divide by one million in six
// 12-bit digits (each a reciprocal-multiply estimate, then a remainder).
// The back end takes a new sample only once the last result is loaded into
// the output register; the first sample skips the gyro work.
// Reset clears the kept angles, the seed flag and restores register
// defaults. A stalled receiver holds the result register; the back end then
// waits and the queue fills before in_ready drops.
module imu_complementary_filter
  import icf_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  icf_if.sink                   in_ch,
  icf_if.source                 out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    q_valid;
  logic    q_ready;
  sample_t q_data;
  logic    busy;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_weight  <= BLEND_WEIGHT_RST;
      cfg.gyro_offset_x <= '0;
      cfg.gyro_offset_y <= '0;
      cfg.gyro_offset_z <= '0;
      cfg.gyro_gain     <= GYRO_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_WEIGHT:  cfg.blend_weight  <= cfg_data[16:0];
        REG_GYRO_OFFSET_X: cfg.gyro_offset_x <= cfg_data[15:0];
        REG_GYRO_OFFSET_Y: cfg.gyro_offset_y <= cfg_data[15:0];
        REG_GYRO_OFFSET_Z: cfg.gyro_offset_z <= cfg_data[15:0];
        REG_GYRO_GAIN:     cfg.gyro_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  icf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  icf_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_data  (out_ch.data),
    .busy      (busy)
  );

  // A pending result means the back end is busy.
  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> busy)
    else $error("result pending while back end idle");

  // A taken queue entry starts work on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (q_valid && q_ready) |=> busy)
    else $error("queue pop without back end start");

endmodule

@@ verif/imu_complementary_filter_tb.sv @@
// Self-checking testbench for the tilt and gyro fusion block.
`timescale 1ns / 1ps
module imu_complementary_filter_tb;
  import icf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 400;

  localparam longint ATAN_Q24 [16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335
  };

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  icf_if #(.payload_t(sample_t)) in_ch ();
  icf_if #(.payload_t(result_t)) out_ch ();

  imu_complementary_filter DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model copy of registers and kept angles
  logic [16:0]     mdl_weight;
  longint          mdl_off_x, mdl_off_y, mdl_off_z;
  longint unsigned mdl_gain;
  longint          kept_x, kept_y, kept_z;
  bit              kept_seeded;

  result_t pending_results[$];
  int      fail_count;
  int      cycle_count;
  bit      idle_on;
  bit      hold_req;
  bit      use_typed;
  result_t typed_result;

  // Directed stimulus rows
  typedef struct {
    sample_t smp;
    bit      typed;
  } row_t;

  always #4 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint sat_32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Negated atan2 of num over the magnitude of p and q, Q16.16 degrees
  function automatic longint tilt_angle(longint num, longint p, longint q);
    longint unsigned sq;
    longint x, y, z, dx, dy;
    sq = longint'(p * p) + longint'(q * q);
    x = longint'(int_sqrt(sq << 16));
    y = num * 256;
    z = 0;
    if (num == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q24[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q24[i];
      end
    end
    z = (z + 128) >>> 8;
    return -z;
  endfunction

  function automatic longint gyro_step(longint rate, longint offset, longint unsigned us);
    longint d;
    longint unsigned mag, t, inc;
    d = rate - offset;
    mag = (d < 0) ? -d : d;
    t = (mag * mdl_gain) >> 16;
    inc = (t * us + 64'd500000) / 64'd1000000;
    return (d < 0) ? -longint'(inc) : longint'(inc);
  endfunction

  function automatic longint fuse_angle(longint kept, longint inc, longint tilt);
    longint k, s, acc;
    k = (mdl_weight > WEIGHT_ONE) ? 65536 : longint'(mdl_weight);
    s = sat_32(kept + inc);
    acc = k * s + (65536 - k) * tilt + 32768;
    return sat_32(acc >>> 16);
  endfunction

  // Advance the model by one sample and return its result
  function automatic result_t fuse_sample(sample_t s);
    result_t r;
    longint tx, ty, tz;
    longint unsigned us;
    us = 64'(s.elapsed_us);
    tx = tilt_angle(s.accel_y, s.accel_x, s.accel_z);
    ty = tilt_angle(s.accel_x, s.accel_y, s.accel_z);
    tz = tilt_angle(s.accel_z, s.accel_y, s.accel_x);
    if (!kept_seeded) begin
      kept_x = sat_32(tx);
      kept_y = sat_32(ty);
      kept_z = sat_32(tz);
      kept_seeded = 1;
    end else begin
      kept_x = fuse_angle(kept_x, gyro_step(s.rate_x, mdl_off_x, us), tx);
      kept_y = fuse_angle(kept_y, gyro_step(s.rate_y, mdl_off_y, us), ty);
      kept_z = fuse_angle(kept_z, gyro_step(s.rate_z, mdl_off_z, us), tz);
    end
    r.fused_x = kept_x[31:0];
    r.fused_y = kept_y[31:0];
    r.fused_z = kept_z[31:0];
    r.tilt_x = tx[23:0];
    r.tilt_y = ty[23:0];
    r.tilt_z = tz[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    result_t r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      r = fuse_sample(in_ch.data);
      pending_results.push_back(use_typed ? typed_result : r);
    end
  end

  // Check every accepted output transaction
  always @(posedge clk) begin
    result_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $display("[%0t] result with no sample pending", $time);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.fused_x !== want.fused_x) report_mismatch("fused_x", got.fused_x, want.fused_x);
        if (got.fused_y !== want.fused_y) report_mismatch("fused_y", got.fused_y, want.fused_y);
        if (got.fused_z !== want.fused_z) report_mismatch("fused_z", got.fused_z, want.fused_z);
        if (got.tilt_x !== want.tilt_x) report_mismatch("tilt_x", got.tilt_x, want.tilt_x);
        if (got.tilt_y !== want.tilt_y) report_mismatch("tilt_y", got.tilt_y, want.tilt_y);
        if (got.tilt_z !== want.tilt_z) report_mismatch("tilt_z", got.tilt_z, want.tilt_z);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLEND_WEIGHT:  mdl_weight = value[16:0];
      REG_GYRO_OFFSET_X: mdl_off_x = longint'($signed(value[15:0]));
      REG_GYRO_OFFSET_Y: mdl_off_y = longint'($signed(value[15:0]));
      REG_GYRO_OFFSET_Z: mdl_off_z = longint'($signed(value[15:0]));
      REG_GYRO_GAIN:     mdl_gain = value;
      default: ;
    endcase
  endtask

  // Offer one sample and hold it until accepted; valid drops only for a random idle gap
  task automatic send_sample(sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid at once, wait for every pending result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(bit long_dt);
    sample_t s;
    s.accel_x = 16'($urandom);
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    // Hold realistic small tilts now and then
    if ($urandom_range(0, 3) == 0) s.accel_x = 16'($urandom_range(0, 255)) - 16'd128;
    if ($urandom_range(0, 7) == 0) s.accel_y = '0;
    s.rate_x = 16'($urandom);
    s.rate_y = 16'($urandom);
    s.rate_z = 16'($urandom);
    s.elapsed_us = (long_dt || $urandom_range(0, 7) == 0) ? 20'($urandom) :
                   20'($urandom_range(0, 20000));
    s.seed = 1'b0;
    return s;
  endfunction

  function automatic sample_t mk(int ax, int ay, int az, int rx, int ry, int rz, int dt);
    sample_t s;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.rate_x = 16'(rx); s.rate_y = 16'(ry); s.rate_z = 16'(rz);
    s.elapsed_us = 20'(dt);
    s.seed = 1'b0;
    return s;
  endfunction

  initial begin
    row_t rows[$];
    clk = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    idle_on = 1;
    hold_req = 0;
    use_typed = 0;
    typed_result = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    mdl_weight = BLEND_WEIGHT_RST;
    mdl_off_x = 0; mdl_off_y = 0; mdl_off_z = 0;
    mdl_gain = GYRO_GAIN_RST;
    kept_x = 0; kept_y = 0; kept_z = 0;
    kept_seeded = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: seeding with zero counts, zero numerators, extremes
    rows.push_back('{mk(0, 0, 0, 1234, -99, 77, 5000), 1});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1});
    rows.push_back('{mk(0, 0, 16384, 100, -100, 0, 10000), 0});
    rows.push_back('{mk(16384, 0, 0, 0, 0, 0, 10000), 0});
    rows.push_back('{mk(0, -16384, 0, 0, 0, 0, 10000), 0});
    rows.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767, 1048575), 0});
    rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768, 1048575), 0});
    rows.push_back('{mk(-32768, 0, 0, 32767, -32768, 1, 1), 0});
    rows.push_back('{mk(0, 32767, 0, -1, 1, -32768, 0), 0});
    rows.push_back('{mk(1, -1, 1, 0, 0, 0, 2500), 0});
    rows.push_back('{mk(-32768, 32767, 1, 500, 500, 500, 20000), 0});
    rows.push_back('{mk(100, -200, 16000, -32768, 32767, 0, 1048575), 0});
    foreach (rows[i]) begin
      use_typed <= rows[i].typed;
      typed_result = '0;
      send_sample(rows[i].smp);
    end
    use_typed <= 1'b0;
    drain();

    // Full gyro weight, extreme offsets and gain: sums saturate
    write_reg(REG_BLEND_WEIGHT, 32'(WEIGHT_ONE));
    write_reg(REG_GYRO_OFFSET_X, 32'h0000_7FFF);
    write_reg(REG_GYRO_OFFSET_Y, 32'hFFFF_8000);
    write_reg(REG_GYRO_OFFSET_Z, 32'h0000_1234);
    write_reg(REG_GYRO_GAIN, 32'hFFFF_FFFF);
    repeat (100) send_sample(rand_sample(1));
    // Pause the sender until the block has emptied
    drain();

    // Tilt only, no gyro; run without idling
    idle_on = 0;
    write_reg(REG_BLEND_WEIGHT, 32'd0);
    write_reg(REG_GYRO_OFFSET_X, 32'd0);
    write_reg(REG_GYRO_OFFSET_Y, 32'd0);
    write_reg(REG_GYRO_OFFSET_Z, 32'd0);
    write_reg(REG_GYRO_GAIN, 32'd0);
    repeat (80) send_sample(rand_sample(0));
    drain();

    // Weight above one and an unused index; long receiver hold-off
    idle_on = 1;
    write_reg(REG_BLEND_WEIGHT, 32'h0001_FFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(REG_GYRO_GAIN, 32'(GYRO_GAIN_RST));
    write_reg(REG_GYRO_OFFSET_X, 32'hFFFF_FFF0);
    hold_req = 1;
    repeat (80) send_sample(rand_sample(0));
    drain();

    // Random settings
    repeat (4) begin
      write_reg(REG_BLEND_WEIGHT, $urandom_range(0, 131071));
      write_reg(REG_GYRO_OFFSET_X, $urandom);
      write_reg(REG_GYRO_OFFSET_Y, $urandom);
      write_reg(REG_GYRO_OFFSET_Z, $urandom);
      write_reg(REG_GYRO_GAIN, ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 26));
      repeat (60) send_sample(rand_sample(0));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ imu_complementary_filter.f @@
hw/rtl/icf_pkg.sv
hw/rtl/icf_if.sv
hw/rtl/icf_front.sv
hw/rtl/icf_back.sv
hw/rtl/imu_complementary_filter.sv
verif/imu_complementary_filter_tb.sv
